// ----- rtl/lspq_pkg.sv -----
// Shared types and constants for the linear scan priority queue.
package lspq_pkg;

  localparam int unsigned OpBits     = 3;
  localparam int unsigned StatusBits = 3;
  localparam int unsigned CountBits  = 5;

  typedef enum logic [OpBits-1:0] {
    OP_ENQ  = 3'd0,
    OP_DEQ  = 3'd1,
    OP_PEEK = 3'd2,
    OP_CHG  = 3'd3,
    OP_CLR  = 3'd4
  } op_e;

  typedef enum logic [StatusBits-1:0] {
    ST_OK          = 3'd0,
    ST_EMPTY       = 3'd1,
    ST_FULL        = 3'd2,
    ST_NOT_FOUND   = 3'd3,
    ST_NOT_UPGRADE = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_DQ_INIT,
    S_SHIFT,
    S_WALK,
    S_FINISH
  } state_e;

  typedef struct packed {
    logic accept;
    logic exec;
    logic scan;
    logic shift_init;
    logic shift;
    logic dec;
    logic walk;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    op_e  op;
    logic empty;
    logic issue_done;
    logic walk_stop;
    logic out_free;
  } sts_t;

endpackage

// ----- rtl/lspq_ctrl.sv -----
// Sequencing state machine for the linear scan priority queue.
module lspq_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  lspq_pkg::sts_t sts_i,
  output lspq_pkg::cmd_t cmd_o
);
  import lspq_pkg::*;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_EXEC;
      end
      S_EXEC: begin
        unique case (sts_i.op)
          OP_DEQ, OP_PEEK: state_d = sts_i.empty ? S_FINISH : S_SCAN;
          OP_CHG:          state_d = sts_i.empty ? S_FINISH : S_WALK;
          default:         state_d = S_FINISH;
        endcase
      end
      S_SCAN: begin
        if (sts_i.issue_done) state_d = (sts_i.op == OP_DEQ) ? S_DQ_INIT : S_FINISH;
      end
      S_DQ_INIT: state_d = S_SHIFT;
      S_SHIFT: begin
        if (sts_i.issue_done) state_d = S_FINISH;
      end
      S_WALK: begin
        if (sts_i.issue_done || sts_i.walk_stop) state_d = S_FINISH;
      end
      S_FINISH: begin
        if (sts_i.out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.accept  = in_valid_i;
      end
      S_EXEC:    cmd_o.exec       = 1'b1;
      S_SCAN:    cmd_o.scan       = 1'b1;
      S_DQ_INIT: cmd_o.shift_init = 1'b1;
      S_SHIFT: begin
        cmd_o.shift = 1'b1;
        cmd_o.dec   = sts_i.issue_done;
      end
      S_WALK:    cmd_o.walk       = 1'b1;
      S_FINISH:  cmd_o.load_out   = sts_i.out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- rtl/lspq_dpath.sv -----
// Entry store, scan registers and result register of the priority queue.
module lspq_dpath #(
  parameter int unsigned CAPACITY      = 16,
  parameter int unsigned VALUE_BITS    = 32,
  parameter int unsigned PRIORITY_BITS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  lspq_pkg::cmd_t                      cmd_i,
  output lspq_pkg::sts_t                      sts_o,
  input  logic [lspq_pkg::OpBits-1:0]         op_i,
  input  logic [VALUE_BITS-1:0]               item_value_i,
  input  logic signed [PRIORITY_BITS-1:0]     item_priority_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [VALUE_BITS-1:0]               out_value_o,
  output logic signed [PRIORITY_BITS-1:0]     out_priority_o,
  output logic [lspq_pkg::CountBits-1:0]      entry_count_o,
  output logic [lspq_pkg::StatusBits-1:0]     status_o
);
  import lspq_pkg::*;

  localparam int unsigned IdxW = $clog2(CAPACITY);
  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  logic [VALUE_BITS-1:0]           mem_val [CAPACITY];
  logic signed [PRIORITY_BITS-1:0] mem_pri [CAPACITY];

  op_e                             op_q;
  logic [VALUE_BITS-1:0]           val_q;
  logic signed [PRIORITY_BITS-1:0] pri_q;

  logic [CntW-1:0]                 cnt_q, cnt_d;
  logic [CntW-1:0]                 iss_q, iss_d;
  logic                            rd_vld_q, rd_vld_d;
  logic [IdxW-1:0]                 rd_idx_q;
  logic [VALUE_BITS-1:0]           rd_val_q;
  logic signed [PRIORITY_BITS-1:0] rd_pri_q;

  logic                            best_vld_q, best_vld_d;
  logic [IdxW-1:0]                 best_idx_q;
  logic [VALUE_BITS-1:0]           best_val_q;
  logic signed [PRIORITY_BITS-1:0] best_pri_q;
  logic                            found_q, found_d;
  status_e                         status_q, status_d;
  logic                            out_valid_q, out_valid_d;

  logic                            full, empty, issue;
  logic                            rd_match, rd_upgrade, rd_better, best_take;
  logic                            we_val, we_pri;
  logic [IdxW-1:0]                 wr_addr;
  logic signed [PRIORITY_BITS-1:0] wr_pri;
  status_e                         fin_status;
  logic                            has_result;

  assign full       = (cnt_q == CntW'(CAPACITY));
  assign empty      = (cnt_q == '0);
  assign issue      = (cmd_i.scan || cmd_i.shift || cmd_i.walk) && (iss_q < cnt_q);
  assign rd_match   = (rd_val_q == val_q);
  assign rd_upgrade = (rd_pri_q > pri_q);
  assign rd_better  = !best_vld_q || (rd_pri_q < best_pri_q) ||
                      ((rd_pri_q == best_pri_q) && (rd_val_q < best_val_q));
  assign best_take  = cmd_i.scan && rd_vld_q && rd_better;

  always_comb begin
    sts_o.op         = op_q;
    sts_o.empty      = empty;
    sts_o.issue_done = (iss_q == cnt_q);
    sts_o.walk_stop  = rd_vld_q && rd_match && !rd_upgrade;
    sts_o.out_free   = !out_valid_q || out_ready_i;
  end

  // single write port shared by enqueue, dequeue compaction and priority change
  always_comb begin
    we_val  = 1'b0;
    we_pri  = 1'b0;
    wr_addr = rd_idx_q;
    wr_pri  = rd_pri_q;
    if (cmd_i.exec && (op_q == OP_ENQ) && !full) begin
      we_val  = 1'b1;
      we_pri  = 1'b1;
      wr_addr = cnt_q[IdxW-1:0];
      wr_pri  = pri_q;
    end else if (cmd_i.shift && rd_vld_q) begin
      we_val  = 1'b1;
      we_pri  = 1'b1;
      wr_addr = rd_idx_q - IdxW'(1);
    end else if (cmd_i.walk && rd_vld_q && rd_match && rd_upgrade) begin
      we_pri  = 1'b1;
      wr_pri  = pri_q;
    end
  end

  always_comb begin
    cnt_d      = cnt_q;
    iss_d      = iss_q;
    rd_vld_d   = issue;
    best_vld_d = best_vld_q;
    found_d    = found_q;
    status_d   = status_q;
    if (cmd_i.accept) begin
      iss_d      = '0;
      best_vld_d = 1'b0;
      found_d    = 1'b0;
      status_d   = ST_OK;
    end
    if (cmd_i.exec) begin
      unique case (op_q)
        OP_ENQ: begin
          if (full) status_d = ST_FULL;
          else      cnt_d    = cnt_q + CntW'(1);
        end
        OP_DEQ, OP_PEEK, OP_CHG: begin
          if (empty) status_d = ST_EMPTY;
        end
        OP_CLR:  cnt_d = '0;
        default: ;
      endcase
    end
    if (cmd_i.shift_init) iss_d = CntW'(best_idx_q) + CntW'(1);
    if (issue)            iss_d = iss_q + CntW'(1);
    if (best_take)        best_vld_d = 1'b1;
    if (cmd_i.dec)        cnt_d = cnt_q - CntW'(1);
    if (cmd_i.walk && rd_vld_q && rd_match) begin
      found_d = 1'b1;
      if (!rd_upgrade) status_d = ST_NOT_UPGRADE;
    end
    out_valid_d = cmd_i.load_out || (out_valid_q && !out_ready_i);
  end

  assign fin_status = ((op_q == OP_CHG) && (status_q == ST_OK) && !found_q) ?
                      ST_NOT_FOUND : status_q;
  assign has_result = ((op_q == OP_DEQ) || (op_q == OP_PEEK)) && (status_q == ST_OK);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      iss_q       <= '0;
      rd_vld_q    <= 1'b0;
      best_vld_q  <= 1'b0;
      found_q     <= 1'b0;
      status_q    <= ST_OK;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      iss_q       <= iss_d;
      rd_vld_q    <= rd_vld_d;
      best_vld_q  <= best_vld_d;
      found_q     <= found_d;
      status_q    <= status_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q  <= op_e'(op_i);
      val_q <= item_value_i;
      pri_q <= item_priority_i;
    end
    if (best_take) begin
      best_idx_q <= rd_idx_q;
      best_val_q <= rd_val_q;
      best_pri_q <= rd_pri_q;
    end
    if (cmd_i.load_out) begin
      out_value_o    <= has_result ? best_val_q : '0;
      out_priority_o <= has_result ? best_pri_q : '0;
      entry_count_o  <= CountBits'(cnt_q);
      status_o       <= fin_status;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      rd_idx_q <= iss_q[IdxW-1:0];
      rd_val_q <= mem_val[iss_q[IdxW-1:0]];
      rd_pri_q <= mem_pri[iss_q[IdxW-1:0]];
    end
    if (we_val) mem_val[wr_addr] <= rd_vld_q && cmd_i.shift ? rd_val_q : val_q;
    if (we_pri) mem_pri[wr_addr] <= wr_pri;
  end

  assign out_valid_o = out_valid_q;

endmodule

// ----- rtl/linear_scan_priority_queue.sv -----
// Top level of the linear scan priority queue: controller, datapath and checks.
// Holds up to CAPACITY entries (value tag, signed priority) in insertion order in
// a one-read, one-write memory. One item is worked on at a time. Enqueue, clear,
// unknown ops and any op on an empty store go straight from execution to the result.
// Peek and change priority read the n stored entries one per cycle through the
// memory read port (change stops early at a match that is not an upgrade). Dequeue
// then shifts each entry after the removed one down one place to close the gap. The
// result sits in an output register; the next item is taken while it waits, and its
// own result waits until that register frees.
module linear_scan_priority_queue #(
  parameter int unsigned CAPACITY      = 16,
  parameter int unsigned VALUE_BITS    = 32,
  parameter int unsigned PRIORITY_BITS = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [lspq_pkg::OpBits-1:0]        op_i,
  input  logic [VALUE_BITS-1:0]              item_value_i,
  input  logic signed [PRIORITY_BITS-1:0]    item_priority_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [VALUE_BITS-1:0]              out_value_o,
  output logic signed [PRIORITY_BITS-1:0]    out_priority_o,
  output logic [lspq_pkg::CountBits-1:0]     entry_count_o,
  output logic [lspq_pkg::StatusBits-1:0]    status_o
);
  import lspq_pkg::*;

  cmd_t cmd;
  sts_t sts;

  lspq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  lspq_dpath #(
    .CAPACITY      (CAPACITY),
    .VALUE_BITS    (VALUE_BITS),
    .PRIORITY_BITS (PRIORITY_BITS)
  ) u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .op_i            (op_i),
    .item_value_i    (item_value_i),
    .item_priority_i (item_priority_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .out_value_o     (out_value_o),
    .out_priority_o  (out_priority_o),
    .entry_count_o   (entry_count_o),
    .status_o        (status_o)
  );

  a_idle_no_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !(cmd.scan || cmd.shift || cmd.walk || cmd.exec))
    else $error("scan command while ready for an item");

  a_load_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |=> out_valid_o)
    else $error("result load did not raise out_valid");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == ST_FULL)) |-> (entry_count_o == CountBits'(CAPACITY)))
    else $error("full status with count below capacity");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == ST_EMPTY)) |->
      ((entry_count_o == '0) && (out_value_o == '0) && (out_priority_o == '0)))
    else $error("empty status with nonzero result fields");

endmodule
